### rtl/core/fbld_pkg.sv
// Shared constants, opcodes and address helper for the framebuffer line drawer.
package fbld_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int PIX_W         = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LINE  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Row-major pixel index; caller guarantees the point is on screen.
    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [10:0] x,
                                                     input logic [10:0] y);
        logic [ADDR_W+11:0] p;
        p = ({{(ADDR_W+1){1'b0}}, y} * (ADDR_W+12)'(SCREEN_WIDTH))
            + {{(ADDR_W+1){1'b0}}, x};
        return p[ADDR_W-1:0];
    endfunction

    function automatic logic on_screen_at(input logic signed [13:0] x,
                                          input logic signed [13:0] y);
        return (x >= 14'sd0) && (x < $signed(14'(SCREEN_WIDTH)))
            && (y >= 14'sd0) && (y < $signed(14'(SCREEN_HEIGHT)));
    endfunction

endpackage

### rtl/core/fbld_ram.sv
// Generic single-port synchronous RAM with registered read.
module fbld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/framebuffer_line_drawer.sv
// Framebuffer line drawer: 240x320 16-bit pixel store with clear, line draw and pixel read.
// One transaction at a time. After reset the store is swept to zero over all SCREEN_WIDTH *
// SCREEN_HEIGHT (76800) pixels with input stalled; a clear op does the same sweep and then
// returns a result. A line is drawn one pixel per cycle through the single RAM port, minor
// coordinate tracked by an incremental quotient/remainder. A read captures the registered
// RAM output in S_RD. The next transaction is taken while the result waits at the output.
module framebuffer_line_drawer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic signed [11:0] i_x_start,
    input  logic signed [11:0] i_y_start,
    input  logic signed [11:0] i_x_end,
    input  logic signed [11:0] i_y_end,
    input  logic [15:0] i_pixel_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_pixel,
    output logic        o_on_screen
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_LINE, S_RD, S_DONE} t_state;

    t_state r_state;
    logic [fbld_pkg::ADDR_W-1:0] r_cnt;
    logic        r_clr_res;
    logic        r_out_valid;
    logic [15:0] r_read_pixel;
    logic        r_on_screen;
    logic [15:0] r_res_pix;
    logic        r_res_on;

    logic signed [11:0] r_maj, r_maj_end, r_min_base;
    logic        r_xmaj, r_dn, r_neg;
    logic [11:0] r_q, r_r, r_dmin, r_dmaj;
    logic [15:0] r_color;

    logic ram_we;
    logic [fbld_pkg::ADDR_W-1:0] ram_addr;
    logic [15:0] ram_wdata, ram_rdata;

    // line setup from input
    logic signed [12:0] dx, dy;
    logic [12:0] adx13, ady13;
    logic [11:0] adx, ady, dmaj, dmin;
    logic        xmaj;
    logic signed [11:0] maj_s, maj_e, min_s, min_e;

    assign dx    = 13'(i_x_start) - 13'(i_x_end);
    assign dy    = 13'(i_y_start) - 13'(i_y_end);
    assign adx13 = dx[12] ? 13'(-dx) : 13'(dx);
    assign ady13 = dy[12] ? 13'(-dy) : 13'(dy);
    assign adx   = adx13[11:0];
    assign ady   = ady13[11:0];
    assign xmaj  = adx > ady;
    assign maj_s = xmaj ? i_x_start : i_y_start;
    assign maj_e = xmaj ? i_x_end   : i_y_end;
    assign min_s = xmaj ? i_y_start : i_x_start;
    assign min_e = xmaj ? i_y_end   : i_x_end;
    assign dmaj  = xmaj ? adx : ady;
    assign dmin  = xmaj ? ady : adx;

    logic rd_in;
    assign rd_in = fbld_pkg::on_screen_at(14'(i_x_start), 14'(i_y_start));

    // current line pixel
    logic signed [13:0] minor, major, px, py;
    logic pix_in;
    logic [12:0] nr;

    assign minor  = r_neg ? 14'(r_min_base) - $signed({2'b00, r_q})
                          : 14'(r_min_base) + $signed({2'b00, r_q});
    assign major  = 14'(r_maj);
    assign px     = r_xmaj ? major : minor;
    assign py     = r_xmaj ? minor : major;
    assign pix_in = fbld_pkg::on_screen_at(px, py);
    assign nr     = {1'b0, r_r} + {1'b0, r_dmin};

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = r_color;
        ram_addr  = fbld_pkg::pixel_addr(i_x_start[10:0], i_y_start[10:0]);
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = r_cnt;
                ram_wdata = '0;
            end
            S_LINE: begin
                ram_we   = pix_in;
                ram_addr = fbld_pkg::pixel_addr(px[10:0], py[10:0]);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fbld_ram #(
        .WIDTH (fbld_pkg::PIX_W),
        .DEPTH (fbld_pkg::PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_clr_res   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res_pix <= '0;
                        r_res_on  <= 1'b0;
                        case (fbld_pkg::t_op'(i_op))
                            fbld_pkg::OP_CLEAR: begin
                                r_cnt     <= '0;
                                r_clr_res <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            fbld_pkg::OP_LINE: begin
                                r_xmaj     <= xmaj;
                                r_maj      <= maj_s;
                                r_maj_end  <= maj_e;
                                r_dn       <= maj_s > maj_e;
                                r_min_base <= min_s;
                                r_neg      <= min_s > min_e;
                                r_dmin     <= dmin;
                                r_dmaj     <= (dmaj == 12'd0) ? 12'd1 : dmaj;
                                r_q        <= '0;
                                r_r        <= '0;
                                r_color    <= i_pixel_color;
                                r_state    <= S_LINE;
                            end
                            fbld_pkg::OP_READ: begin
                                r_state <= rd_in ? S_RD : S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_cnt == fbld_pkg::ADDR_W'(fbld_pkg::PIXELS - 1)) begin
                        r_state   <= r_clr_res ? S_DONE : S_IDLE;
                        r_clr_res <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + fbld_pkg::ADDR_W'(1);
                    end
                end
                S_LINE: begin
                    if (r_maj == r_maj_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_maj <= r_dn ? r_maj - 12'sd1 : r_maj + 12'sd1;
                        if (nr >= {1'b0, r_dmaj}) begin
                            r_r <= 12'(nr - {1'b0, r_dmaj});
                            r_q <= r_q + 12'd1;
                        end else begin
                            r_r <= nr[11:0];
                        end
                    end
                end
                S_RD: begin
                    r_res_pix <= ram_rdata;
                    r_res_on  <= 1'b1;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_read_pixel <= r_res_pix;
                        r_on_screen  <= r_res_on;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_pixel = r_read_pixel;
    assign o_on_screen  = r_on_screen;

endmodule

### rtl/core/fbld_checker.sv
// Port-level assertions for the framebuffer line drawer, bound to the top level.
module fbld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_read_pixel,
    input logic        o_on_screen
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_pixel)
            && $stable(o_on_screen))
        else $error("stalled result changed");

    // off-screen or non-read results carry zero pixel
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_on_screen |-> o_read_pixel == 16'd0)
        else $error("nonzero pixel without on_screen");

    // one transaction in flight: busy right after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // clearing sweep holds input off after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("not stalled after reset");

endmodule

bind framebuffer_line_drawer fbld_checker u_fbld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_pixel (o_read_pixel),
    .o_on_screen  (o_on_screen)
);

### tb/framebuffer_line_drawer_test.sv
// Testbench for the framebuffer line drawer: clear, line draw and pixel read against a pixel model.
`timescale 1ns / 1ps

module framebuffer_line_drawer_test;

    typedef struct {
        logic [15:0] pixel;
        logic        on;
    } t_read_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_op = fbld_pkg::OP_NONE;
    logic signed [11:0] i_x_start = '0;
    logic signed [11:0] i_y_start = '0;
    logic signed [11:0] i_x_end = '0;
    logic signed [11:0] i_y_end = '0;
    logic [15:0]        i_pixel_color = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [15:0]        o_read_pixel;
    logic               o_on_screen;

    logic [15:0]  pixel_model [0:fbld_pkg::PIXELS-1];
    t_read_result pending_reads [$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    int           rx_hold = 0;

    framebuffer_line_drawer i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic bit on_grid(int x, int y);
        return x >= 0 && x < fbld_pkg::SCREEN_WIDTH && y >= 0 && y < fbld_pkg::SCREEN_HEIGHT;
    endfunction

    function automatic void model_plot(int x, int y, logic [15:0] c);
        if (on_grid(x, y)) pixel_model[y * fbld_pkg::SCREEN_WIDTH + x] = c;
    endfunction

    function automatic void model_line(int sx, int sy, int ex, int ey, logic [15:0] c);
        int dx, dy, ddx, ddy, stp, k;
        dx = sx - ex;
        dy = sy - ey;
        ddx = (dx == 0) ? 1 : dx;
        ddy = (dy == 0) ? 1 : dy;
        if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
            stp = (sx > ex) ? -1 : 1;
            for (k = sx; ; k += stp) begin
                model_plot(k, (k - sx) * dy / ddx + sy, c);
                if (k == ex) break;
            end
        end else begin
            stp = (sy > ey) ? -1 : 1;
            for (k = sy; ; k += stp) begin
                model_plot((k - sy) * dx / ddy + sx, k, c);
                if (k == ey) break;
            end
        end
    endfunction

    // Applies one transaction to the pixel model and returns the read result it produces.
    function automatic t_read_result model_apply(fbld_pkg::t_op op, int xs, int ys, int xe,
                                                 int ye, logic [15:0] c);
        t_read_result r;
        r.pixel = '0;
        r.on = 1'b0;
        case (op)
            fbld_pkg::OP_CLEAR: foreach (pixel_model[i]) pixel_model[i] = '0;
            fbld_pkg::OP_LINE:  model_line(xs, ys, xe, ye, c);
            fbld_pkg::OP_READ: begin
                if (on_grid(xs, ys)) begin
                    r.pixel = pixel_model[ys * fbld_pkg::SCREEN_WIDTH + xs];
                    r.on = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(fbld_pkg::t_op op, int xs, int ys, int xe, int ye, int c);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_x_start     <= xs[11:0];
        i_y_start     <= ys[11:0];
        i_x_end       <= xe[11:0];
        i_y_end       <= ye[11:0];
        i_pixel_color <= c[15:0];
        do @(posedge i_clk); while (o_in_stall);
        pending_reads.push_back(model_apply(op, xs, ys, xe, ye, c[15:0]));
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Result checker plus receiver back-pressure.
    initial begin
        t_read_result want;
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch("unexpected result", o_read_pixel, 0);
                end else begin
                    want = pending_reads.pop_front();
                    if (o_read_pixel !== want.pixel)
                        report_mismatch("read_pixel", o_read_pixel, want.pixel);
                    if (o_on_screen !== want.on)
                        report_mismatch("on_screen", o_on_screen, want.on);
                end
                wait_left = idle_on ? $urandom_range(0, 19) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int rand12();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic test_reset_state();
        send_item(fbld_pkg::OP_READ, 0, 0, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, fbld_pkg::SCREEN_WIDTH - 1, fbld_pkg::SCREEN_HEIGHT - 1,
                  0, 0, 0);
        send_item(fbld_pkg::OP_NONE, 5, 5, 9, 9, 16'hffff);
        wait_drained();
    endtask

    task automatic test_directed_lines();
        send_item(fbld_pkg::OP_LINE, 10, 10, 10, 10, 16'hffff);          // single pixel line
        send_item(fbld_pkg::OP_READ, 10, 10, 0, 0, 0);
        send_item(fbld_pkg::OP_LINE, -2048, -2048, 2047, 2047, 16'h1234); // off edges
        send_item(fbld_pkg::OP_LINE, 0, 0, fbld_pkg::SCREEN_WIDTH - 1, 7, 16'h8001); // x major
        send_item(fbld_pkg::OP_LINE, 3, fbld_pkg::SCREEN_HEIGHT - 1, 0, 0, 16'h00ff); // y back
        send_item(fbld_pkg::OP_LINE, 20, 20, 40, 40, 16'h0f0f);           // tie goes to y
        send_item(fbld_pkg::OP_LINE, 2047, 2047, 2047, 2047, 16'hbeef);   // off-screen point
        send_item(fbld_pkg::OP_READ, 0, 0, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 1, 0, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 30, 30, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 3, fbld_pkg::SCREEN_HEIGHT - 1, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, fbld_pkg::SCREEN_WIDTH, 0, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 0, fbld_pkg::SCREEN_HEIGHT, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, -1, 5, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, -2048, 2047, 0, 0, 0);
        send_item(fbld_pkg::OP_NONE, -1, -1, -1, -1, 16'hffff);
        send_item(fbld_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 10, 10, 0, 0, 0);
        send_item(fbld_pkg::OP_READ, 30, 30, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        for (int i = 0; i < 12; i++)
            send_item(fbld_pkg::OP_READ, $urandom_range(0, 30), $urandom_range(0, 30), 0, 0, 0);
        wait_drained();
    endtask

    task automatic send_random_item();
        int kind, xs, ys, xe, ye;
        kind = $urandom_range(0, 99);
        xs = int'($urandom_range(0, 280)) - 20;
        ys = int'($urandom_range(0, 360)) - 20;
        if (kind < 45) begin
            xe = xs + int'($urandom_range(0, 60)) - 30;
            ye = ys + int'($urandom_range(0, 60)) - 30;
            send_item(fbld_pkg::OP_LINE, xs, ys, xe, ye, $urandom_range(0, 65535));
        end else if (kind < 48) begin
            send_item(fbld_pkg::OP_LINE, rand12(), rand12(), rand12(), rand12(),
                      $urandom_range(0, 65535));
        end else if (kind < 93) begin
            send_item(fbld_pkg::OP_READ, xs, ys, rand12(), rand12(), $urandom_range(0, 65535));
        end else if (kind < 96) begin
            send_item(fbld_pkg::OP_READ, rand12(), rand12(), 0, 0, 0);
        end else begin
            send_item(fbld_pkg::OP_NONE, rand12(), rand12(), rand12(), rand12(),
                      $urandom_range(0, 65535));
        end
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 1350; i++) begin
            if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (i == 700)
                send_item(fbld_pkg::OP_CLEAR, rand12(), rand12(), rand12(), rand12(), 16'hffff);
            send_random_item();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        foreach (pixel_model[i]) pixel_model[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_lines();
        test_backpressure();
        test_random_traffic();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_reads.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### framebuffer_line_drawer.f
rtl/core/fbld_pkg.sv
rtl/core/fbld_ram.sv
rtl/core/framebuffer_line_drawer.sv
rtl/core/fbld_checker.sv
tb/framebuffer_line_drawer_test.sv
